// File: rtl/alec_pkg.sv
// ----------------------------------------------------------------------------
// alec_pkg
// Shared constants and codes for the array list engine: field widths, default
// store geometry, operation codes and error codes.
// ----------------------------------------------------------------------------
package alec_pkg;

   localparam int ALEC_MAX_ENTRIES = 64;
   localparam int ALEC_VALUE_WIDTH = 32;

   localparam int OP_W    = 3;
   localparam int POS_W   = 7;
   localparam int ITEM_W  = 32;
   localparam int ERR_W   = 2;
   localparam int CNT_W   = 7;
   localparam int CAP_W   = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT  = 3'd0,
      OP_REMOVE  = 3'd1,
      OP_SELECT  = 3'd2,
      OP_SEARCH  = 3'd3,
      OP_REPLACE = 3'd4
   } op_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE  = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_RANGE = 2'd2,
      ERR_EMPTY = 2'd3
   } err_type;

endpackage

// File: rtl/array_list_engine_core.sv
// ----------------------------------------------------------------------------
// array_list_engine_core
// Ordered array list kept in one dual-port RAM, with a count register and a
// configurable capacity. Insert and remove move entries one per cycle.
// ----------------------------------------------------------------------------
// Steps to rsp_tvalid: insert and remove move the entries through the RAM and
// then write or drop the item; search scans from index 0 until a hit or the end
// of the list; select reads one RAM word; replace writes it directly; rejected
// items and a search of an empty list go straight to the result register.
// One item is processed at a time; the next item is taken only after the result
// of the last one is loaded into the output register.
// Reset clears the count, sets the capacity to 64 and leaves the RAM contents.
// ----------------------------------------------------------------------------
module array_list_engine_core
   import alec_pkg::*;
#(
   parameter int MAX_ENTRIES = ALEC_MAX_ENTRIES,
   parameter int VALUE_WIDTH = ALEC_VALUE_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   // Request item: tdata = position[6:0], item_value[38:7]; tuser = op[2:0].
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [39:0]       req_tdata,
   input  logic [OP_W-1:0]   req_tuser,
   // Result item: tdata = ok[0], error_code[2:1], read_value[34:3],
   // found_position[41:35], entry_count[48:42], is_full[49], is_empty[50].
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [55:0]       rsp_tdata,
   input  logic              csr_wr_en,
   input  logic [CAP_W-1:0]  csr_wr_data
);

   localparam int CW   = $clog2(MAX_ENTRIES + 1);
   localparam int AW   = $clog2(MAX_ENTRIES);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_SCAN,
      ST_SEL_RD,
      ST_SEL_DATA,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [AW-1:0]    pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [AW-1:0]    ptr_ff, ptr_in;
   logic [AW-1:0]    end_ff, end_in;
   logic [AW-1:0]    dst_ff, dst_in;
   logic             issue_ff, issue_in;
   logic             have_ff, have_in;
   logic             up_ff, up_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CAP_W-1:0] cap_ff, cap_in;

   logic             res_ok_ff, res_ok_in;
   err_type          res_err_ff, res_err_in;
   logic [VALUE_WIDTH-1:0] res_rd_ff, res_rd_in;
   logic [CW-1:0]    res_found_ff, res_found_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_ok_ff, rsp_ok_in;
   err_type          rsp_err_ff, rsp_err_in;
   logic [ITEM_W-1:0] rsp_rd_ff, rsp_rd_in;
   logic [CNT_W-1:0] rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic             rsp_full_ff, rsp_full_in;
   logic             rsp_empty_ff, rsp_empty_in;

   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [VALUE_WIDTH-1:0] ram_wr_data;
   logic                   ram_rd_en;
   logic [AW-1:0]          ram_rd_addr;
   logic [VALUE_WIDTH-1:0] ram_rd_data;

   logic [POS_W-1:0]  req_pos;
   logic [ITEM_W-1:0] req_value;
   logic [CMPW-1:0]   pos_x;
   logic [CMPW-1:0]   cnt_x;
   logic [CMPW-1:0]   cap_x;
   logic              req_fire;
   logic              rsp_load;

   assign req_pos   = req_tdata[POS_W-1:0];
   assign req_value = req_tdata[POS_W+ITEM_W-1:POS_W];
   assign pos_x     = CMPW'(req_pos);
   assign cnt_x     = CMPW'(cnt_ff);
   assign cap_x     = (CMPW'(cap_ff) > CMPW'(MAX_ENTRIES)) ? CMPW'(MAX_ENTRIES)
                                                          : CMPW'(cap_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      dst_in       = dst_ff;
      issue_in     = issue_ff;
      have_in      = have_ff;
      up_in        = up_ff;
      cnt_in       = cnt_ff;
      cap_in       = csr_wr_en ? csr_wr_data : cap_ff;
      res_ok_in    = res_ok_ff;
      res_err_in   = res_err_ff;
      res_rd_in    = res_rd_ff;
      res_found_in = res_found_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = dst_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = ptr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in        = op_type'(req_tuser);
               pos_in       = AW'(req_pos);
               val_in       = VALUE_WIDTH'(req_value);
               res_ok_in    = 1'b0;
               res_err_in   = ERR_NONE;
               res_rd_in    = '0;
               res_found_in = '0;
               have_in      = 1'b0;
               issue_in     = 1'b0;
               case (op_type'(req_tuser))
                  OP_INSERT: begin
                     if (cnt_x >= cap_x) begin
                        res_err_in = ERR_FULL;
                        state_in   = ST_FINISH;
                     end else if (pos_x > cnt_x) begin
                        res_err_in = ERR_RANGE;
                        state_in   = ST_FINISH;
                     end else begin
                        up_in    = 1'b1;
                        issue_in = (pos_x != cnt_x);
                        ptr_in   = AW'(cnt_ff - CW'(1));
                        end_in   = AW'(req_pos);
                        state_in = ST_SHIFT;
                     end
                  end
                  OP_REMOVE: begin
                     if (pos_x >= cnt_x) begin
                        res_err_in = ERR_RANGE;
                        state_in   = ST_FINISH;
                     end else begin
                        up_in    = 1'b0;
                        issue_in = ((pos_x + CMPW'(1)) != cnt_x);
                        ptr_in   = AW'(pos_x + CMPW'(1));
                        end_in   = AW'(cnt_ff - CW'(1));
                        state_in = ST_SHIFT;
                     end
                  end
                  OP_SELECT: begin
                     if (cnt_ff == '0) begin
                        res_err_in = ERR_EMPTY;
                        state_in   = ST_FINISH;
                     end else begin
                        ptr_in   = (pos_x < cnt_x) ? AW'(req_pos) : AW'(cnt_ff - CW'(1));
                        state_in = ST_SEL_RD;
                     end
                  end
                  OP_SEARCH: begin
                     if (cnt_ff == '0) begin
                        res_ok_in = 1'b1;
                        state_in  = ST_FINISH;
                     end else begin
                        issue_in = 1'b1;
                        ptr_in   = '0;
                        end_in   = AW'(cnt_ff - CW'(1));
                        state_in = ST_SCAN;
                     end
                  end
                  OP_REPLACE: begin
                     if (pos_x >= cnt_x) begin
                        res_err_in = ERR_RANGE;
                        state_in   = ST_FINISH;
                     end else begin
                        state_in = ST_SHIFT;
                     end
                  end
                  default: begin
                     res_err_in = ERR_RANGE;
                     state_in   = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            ram_rd_en = issue_ff;
            have_in   = issue_ff;
            if (issue_ff) begin
               dst_in = up_ff ? (ptr_ff + AW'(1)) : (ptr_ff - AW'(1));
               if (ptr_ff == end_ff) begin
                  issue_in = 1'b0;
               end else begin
                  ptr_in = up_ff ? (ptr_ff - AW'(1)) : (ptr_ff + AW'(1));
               end
            end
            if (have_ff) begin
               ram_wr_en = 1'b1;
            end else if (!issue_ff) begin
               res_ok_in = 1'b1;
               state_in  = ST_FINISH;
               case (op_ff)
                  OP_INSERT: begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = pos_ff;
                     ram_wr_data = val_ff;
                     cnt_in      = cnt_ff + CW'(1);
                  end
                  OP_REMOVE: begin
                     cnt_in = cnt_ff - CW'(1);
                  end
                  default: begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = pos_ff;
                     ram_wr_data = val_ff;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            ram_rd_en = issue_ff;
            have_in   = issue_ff;
            if (issue_ff) begin
               dst_in = ptr_ff;
               if (ptr_ff == end_ff) begin
                  issue_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + AW'(1);
               end
            end
            if (have_ff) begin
               if (ram_rd_data == val_ff) begin
                  res_ok_in    = 1'b1;
                  res_found_in = CW'(dst_ff);
                  issue_in     = 1'b0;
                  have_in      = 1'b0;
                  state_in     = ST_FINISH;
               end else if (!issue_ff) begin
                  res_ok_in    = 1'b1;
                  res_found_in = cnt_ff;
                  state_in     = ST_FINISH;
               end
            end
         end
         ST_SEL_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_SEL_DATA;
         end
         ST_SEL_DATA: begin
            res_ok_in = 1'b1;
            res_rd_in = ram_rd_data;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_rd_in    = rsp_rd_ff;
      rsp_found_in = rsp_found_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_empty_in = rsp_empty_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = res_ok_ff;
         rsp_err_in   = res_err_ff;
         rsp_rd_in    = ITEM_W'(res_rd_ff);
         rsp_found_in = CNT_W'(res_found_ff);
         rsp_cnt_in   = CNT_W'(cnt_ff);
         rsp_full_in  = (cnt_x >= cap_x);
         rsp_empty_in = (cnt_ff == '0);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= 1'b0;
         have_ff      <= 1'b0;
         cnt_ff       <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         have_ff      <= have_in;
         cnt_ff       <= cnt_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      ptr_ff       <= ptr_in;
      end_ff       <= end_in;
      dst_ff       <= dst_in;
      up_ff        <= up_in;
      res_ok_ff    <= res_ok_in;
      res_err_ff   <= res_err_in;
      res_rd_ff    <= res_rd_in;
      res_found_ff <= res_found_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_rd_ff    <= rsp_rd_in;
      rsp_found_ff <= rsp_found_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   alec_ram #(
      .WIDTH(VALUE_WIDTH),
      .DEPTH(MAX_ENTRIES)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_empty_ff, rsp_full_ff, rsp_cnt_ff, rsp_found_ff,
                        rsp_rd_ff, rsp_err_ff, rsp_ok_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMPW'(cnt_ff) <= CMPW'(MAX_ENTRIES))
      else $error("Entry count exceeds the store depth.");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(cnt_ff)) |->
         (cnt_ff == $past(cnt_ff) + CW'(1)) || (cnt_ff == $past(cnt_ff) - CW'(1)))
      else $error("Entry count changed by more than one.");

   a_write_in_shift: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_SHIFT))
      else $error("Store written outside a shift or write step.");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("Accepted item did not start processing.");

endmodule

// File: rtl/alec_ram.sv
// ----------------------------------------------------------------------------
// alec_ram
// Generic simple dual-port RAM: one write port and one read port, with the
// read data registered.
// ----------------------------------------------------------------------------
module alec_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for array_list_engine_core. Requests go in on the req_
// stream and every result on the rsp_ stream is compared with a cycle-free
// prediction of the ordered list kept in the bench. It covers the empty list,
// edits at both ends, unknown operations, capacity settings from zero to 127,
// a fill to the full store depth, and long random traffic with random stalls.
// ----------------------------------------------------------------------------
module testbench
   import alec_pkg::*;
();

   typedef struct packed {
      logic        ok;
      logic [1:0]  error_code;
      logic [31:0] read_value;
      logic [6:0]  found_position;
      logic [6:0]  entry_count;
      logic        is_full;
      logic        is_empty;
   } list_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [39:0]       req_tdata = '0;
   logic [OP_W-1:0]   req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [55:0]       rsp_tdata;
   logic              csr_wr_en = 1'b0;
   logic [CAP_W-1:0]  csr_wr_data = '0;

   logic [31:0]       list_mem [ALEC_MAX_ENTRIES];
   int unsigned       list_count = 0;
   logic [CAP_W-1:0]  cap_limit = CAP_RESET;
   list_result_type   pending_results [$];
   bit                idling = 1'b1;
   int                error_count = 0;
   int                total_items = 0;
   int                total_results = 0;
   int                full_refusals = 0;
   int unsigned       peak_count = 0;

   array_list_engine_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   initial begin
      #10_000_000;
      $display("array_list_engine_core test failed");
      $finish;
   end

   function automatic list_result_type apply_list_op(logic [2:0] op, logic [6:0] pos,
                                                     logic [31:0] val);
      list_result_type r;
      int unsigned     usable;
      int unsigned     i;
      r = '0;
      usable = (cap_limit > ALEC_MAX_ENTRIES) ? ALEC_MAX_ENTRIES : cap_limit;
      case (op)
         OP_INSERT: begin
            if (list_count >= usable) begin
               r.error_code = ERR_FULL;
               full_refusals++;
            end else if (pos > list_count) begin
               r.error_code = ERR_RANGE;
            end else begin
               for (i = list_count; i > pos; i--) list_mem[i] = list_mem[i-1];
               list_mem[pos] = val;
               list_count++;
               r.ok = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (pos >= list_count) begin
               r.error_code = ERR_RANGE;
            end else begin
               for (i = pos; i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
               list_count--;
               r.ok = 1'b1;
            end
         end
         OP_SELECT: begin
            if (list_count == 0) begin
               r.error_code = ERR_EMPTY;
            end else begin
               r.read_value = list_mem[(pos < list_count) ? pos : list_count - 1];
               r.ok = 1'b1;
            end
         end
         OP_SEARCH: begin
            i = 0;
            while (i < list_count && list_mem[i] != val) i++;
            r.found_position = 7'(i);
            r.ok = 1'b1;
         end
         OP_REPLACE: begin
            if (pos >= list_count) begin
               r.error_code = ERR_RANGE;
            end else begin
               list_mem[pos] = val;
               r.ok = 1'b1;
            end
         end
         default: begin
            r.error_code = ERR_RANGE;
         end
      endcase
      r.entry_count = 7'(list_count);
      r.is_full = (list_count >= usable);
      r.is_empty = (list_count == 0);
      if (list_count > peak_count) peak_count = list_count;
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         rsp_tready <= !idling || ($urandom_range(99) >= 30);
      end
   end

   initial begin
      list_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            total_results++;
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("ok", 32'(want.ok), 32'(rsp_tdata[0]));
               check_field("error_code", 32'(want.error_code), 32'(rsp_tdata[2:1]));
               check_field("read_value", want.read_value, rsp_tdata[34:3]);
               check_field("found_position", 32'(want.found_position),
                           32'(rsp_tdata[41:35]));
               check_field("entry_count", 32'(want.entry_count), 32'(rsp_tdata[48:42]));
               check_field("is_full", 32'(want.is_full), 32'(rsp_tdata[49]));
               check_field("is_empty", 32'(want.is_empty), 32'(rsp_tdata[50]));
            end
         end
      end
   end

   task automatic send_request(logic [2:0] op, logic [6:0] pos, logic [31:0] val);
      if (idling) begin
         while ($urandom_range(99) < 30) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {1'b0, val, pos};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      pending_results.push_back(apply_list_op(op, pos, val));
      total_items++;
   endtask

   task automatic wait_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      wait_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cap_limit = value;
   endtask

   task automatic send_random_request(int ins_w, int rem_w);
      int          r;
      logic [2:0]  op;
      logic [6:0]  pos;
      logic [31:0] val;
      r = $urandom_range(99);
      if (r < ins_w) begin
         op = OP_INSERT;
      end else if (r < ins_w + rem_w) begin
         op = OP_REMOVE;
      end else begin
         r = $urandom_range(19);
         if (r < 7) op = OP_SELECT;
         else if (r < 14) op = OP_SEARCH;
         else if (r < 19) op = OP_REPLACE;
         else op = 3'($urandom_range(5, 7));
      end
      if ($urandom_range(4) == 0) pos = 7'($urandom_range(127));
      else if (op == OP_INSERT || list_count == 0) pos = 7'($urandom_range(list_count));
      else pos = 7'($urandom_range(list_count - 1));
      case ($urandom_range(3))
         0: val = $urandom_range(5);
         1: val = (list_count > 0) ? list_mem[$urandom_range(list_count - 1)] : 32'hFFFF_FFFF;
         default: val = $urandom;
      endcase
      send_request(op, pos, val);
   endtask

   task automatic run_random_phase(int n, int ins_w, int rem_w);
      repeat (n) begin
         send_random_request(ins_w, rem_w);
         if ($urandom_range(59) == 0) wait_results();
      end
   endtask

   task automatic test_empty_list();
      send_request(OP_SELECT, 7'd0, 32'h0);
      send_request(OP_SELECT, 7'd127, 32'h0);
      send_request(OP_REMOVE, 7'd0, 32'h0);
      send_request(OP_REPLACE, 7'd0, 32'hFFFF_FFFF);
      send_request(OP_SEARCH, 7'd0, 32'h0);
      send_request(OP_INSERT, 7'd1, 32'h1);
   endtask

   task automatic test_basic_edits();
      send_request(OP_INSERT, 7'd0, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 7'd0, 32'h0);
      send_request(OP_INSERT, 7'd2, 32'h1234_5678);
      send_request(OP_INSERT, 7'd4, 32'h5555_5555);
      send_request(OP_SELECT, 7'd127, 32'h0);
      send_request(OP_SELECT, 7'd0, 32'h0);
      send_request(OP_SELECT, 7'd1, 32'h0);
      send_request(OP_SEARCH, 7'd0, 32'h1234_5678);
      send_request(OP_SEARCH, 7'd0, 32'hDEAD_BEEF);
      send_request(OP_REPLACE, 7'd1, 32'hA5A5_A5A5);
      send_request(OP_REPLACE, 7'd3, 32'h1);
      send_request(OP_REMOVE, 7'd3, 32'h0);
      send_request(OP_REMOVE, 7'd0, 32'h0);
      send_request(OP_SEARCH, 7'd0, 32'hA5A5_A5A5);
   endtask

   task automatic test_unknown_ops();
      send_request(3'd5, 7'd0, 32'h0);
      send_request(3'd6, 7'd64, 32'h1);
      send_request(3'd7, 7'd127, 32'hFFFF_FFFF);
   endtask

   task automatic test_capacity_limits();
      // Two entries are held here, so a capacity of one is already exceeded.
      write_capacity(7'd1);
      send_request(OP_INSERT, 7'd99, 32'h7);
      send_request(OP_INSERT, 7'd0, 32'h7);
      send_request(OP_REMOVE, 7'd0, 32'h0);
      write_capacity(7'd0);
      send_request(OP_INSERT, 7'd0, 32'h8);
      send_request(OP_SELECT, 7'd0, 32'h0);
      write_capacity(7'd127);
      send_request(OP_INSERT, 7'd1, 32'h9);
   endtask

   task automatic test_fill_to_depth();
      write_capacity(7'd64);
      while (list_count < ALEC_MAX_ENTRIES) begin
         send_request(OP_INSERT, 7'($urandom_range(list_count)), $urandom);
      end
      send_request(OP_INSERT, 7'd0, 32'h1);
      send_request(OP_INSERT, 7'd64, 32'h1);
      send_request(OP_SELECT, 7'd63, 32'h0);
      send_request(OP_SELECT, 7'd64, 32'h0);
      send_request(OP_SELECT, 7'd127, 32'h0);
      send_request(OP_SEARCH, 7'd0, list_mem[63]);
      write_capacity(7'd127);
      send_request(OP_INSERT, 7'd10, 32'h2);
      send_request(OP_REPLACE, 7'd63, 32'hFFFF_FFFF);
      send_request(OP_REMOVE, 7'd64, 32'h0);
      while (list_count > 0) begin
         send_request(OP_REMOVE, 7'($urandom_range(list_count - 1)), 32'h0);
      end
      send_request(OP_SELECT, 7'd5, 32'h0);
   endtask

   task automatic test_random_traffic();
      write_capacity(7'd64);
      run_random_phase(200, 35, 15);
      write_capacity(7'd127);
      run_random_phase(150, 20, 30);
      write_capacity(7'd7);
      run_random_phase(100, 30, 20);
      write_capacity(7'd1);
      run_random_phase(60, 30, 20);
      write_capacity(7'd0);
      run_random_phase(40, 30, 20);
      write_capacity(CAP_W'($urandom_range(2, 127)));
      run_random_phase(50, 30, 20);
   endtask

   task automatic test_steady_stream();
      idling = 1'b0;
      write_capacity(7'd33);
      run_random_phase(200, 30, 20);
      wait_results();
      idling = 1'b1;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_basic_edits();
      test_unknown_ops();
      test_capacity_limits();
      test_fill_to_depth();
      test_random_traffic();
      test_steady_stream();
      wait_results();
      repeat (100) @(posedge clock);
      $display("Sent %0d items and checked %0d results; capacities 0 to 127 were used.",
               total_items, total_results);
      $display("The list reached %0d entries and %0d inserts were refused as full.",
               peak_count, full_refusals);
      if (error_count == 0) begin
         $display("array_list_engine_core test passed");
      end else begin
         $display("array_list_engine_core test failed");
      end
      $finish;
   end

endmodule
